@@ rtl/core/h2r_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// h2r_pkg
// Shared types and constants of the HSV to RGB converter.
// ----------------------------------------------------------------------------
package h2r_pkg;

    localparam int HUE_W  = 15;
    localparam int SV_W   = 9;
    localparam int CH_W   = 8;
    localparam int DIST_W = 12;
    localparam int VS_W   = 2 * SV_W;

    // One 60 degree sector in 1/64 degree units
    localparam logic [HUE_W-1:0] SECTOR_UNITS = 15'd3840;
    localparam logic [HUE_W-1:0] HUE_60       = 15'd3840;
    localparam logic [HUE_W-1:0] HUE_120      = 15'd7680;
    localparam logic [HUE_W-1:0] HUE_180      = 15'd11520;
    localparam logic [HUE_W-1:0] HUE_240      = 15'd15360;
    localparam logic [HUE_W-1:0] HUE_300      = 15'd19200;
    localparam logic [HUE_W-1:0] HUE_360      = 15'd23040;
    localparam logic [HUE_W-1:0] HUE_480      = 15'd30720;

    // Secondary channel clamps at 255 * 15 before the divide by 15
    localparam logic [DIST_W-1:0] XY_MAX   = 12'd3825;
    // ceil(2^19 / 15): exact floor(y / 15) for y below 2^12
    localparam logic [15:0]       RECIP15  = 16'd34953;
    localparam int                RECIP_SH = 19;

    localparam logic [CH_W-1:0]   CH_MAX   = 8'd255;

    typedef enum logic [2:0] {
        SECTOR_RED_YELLOW    = 3'd0,
        SECTOR_YELLOW_GREEN  = 3'd1,
        SECTOR_GREEN_CYAN    = 3'd2,
        SECTOR_CYAN_BLUE     = 3'd3,
        SECTOR_BLUE_MAGENTA  = 3'd4,
        SECTOR_MAGENTA_RED   = 3'd5
    } sector_t;

    typedef struct packed {
        sector_t             sector;
        logic [DIST_W-1:0]   gap;    // |(hue mod 120 deg) - 60 deg|
    } hue_split_t;

endpackage
`default_nettype wire

@@ rtl/core/h2r_hue_split.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// h2r_hue_split
// Sector select and distance from the sector pair center for one hue.
// ----------------------------------------------------------------------------
module h2r_hue_split (
    input  wire logic [h2r_pkg::HUE_W-1:0] hue,
    output h2r_pkg::hue_split_t            split
);

    logic [12:0] hue_mod;

    always_comb begin
        // hue modulo 120 degrees; a 15-bit hue stays below five full turns of 120
        if (hue < h2r_pkg::HUE_120) begin
            hue_mod = hue[12:0];
        end else if (hue < h2r_pkg::HUE_240) begin
            hue_mod = 13'(hue - h2r_pkg::HUE_120);
        end else if (hue < h2r_pkg::HUE_360) begin
            hue_mod = 13'(hue - h2r_pkg::HUE_240);
        end else if (hue < h2r_pkg::HUE_480) begin
            hue_mod = 13'(hue - h2r_pkg::HUE_360);
        end else begin
            hue_mod = 13'(hue - h2r_pkg::HUE_480);
        end
    end

    always_comb begin
        if (hue_mod >= h2r_pkg::SECTOR_UNITS[12:0]) begin
            split.gap = h2r_pkg::DIST_W'(hue_mod - h2r_pkg::SECTOR_UNITS[12:0]);
        end else begin
            split.gap = h2r_pkg::DIST_W'(h2r_pkg::SECTOR_UNITS[12:0] - hue_mod);
        end

        // Hue at or past 360 degrees stays in the last sector
        if (hue < h2r_pkg::HUE_60) begin
            split.sector = h2r_pkg::SECTOR_RED_YELLOW;
        end else if (hue < h2r_pkg::HUE_120) begin
            split.sector = h2r_pkg::SECTOR_YELLOW_GREEN;
        end else if (hue < h2r_pkg::HUE_180) begin
            split.sector = h2r_pkg::SECTOR_GREEN_CYAN;
        end else if (hue < h2r_pkg::HUE_240) begin
            split.sector = h2r_pkg::SECTOR_CYAN_BLUE;
        end else if (hue < h2r_pkg::HUE_300) begin
            split.sector = h2r_pkg::SECTOR_BLUE_MAGENTA;
        end else begin
            split.sector = h2r_pkg::SECTOR_MAGENTA_RED;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/hsv_to_rgb_converter.sv @@
// An accepted input beat passes the stage 1 to 4 registers before its result shows on m_*.
// Throughput: one beat per cycle; four register stages each move on when
// the stage after them is empty or advancing, so a stall holds every beat.
// Reset (aresetn low, synchronous) clears all stage valid bits; payload
// registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// HSV to 8-bit RGB conversion in exact fixed point, four pipeline stages.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [h2r_pkg::HUE_W-1:0]  s_hue,
    input  wire logic [h2r_pkg::SV_W-1:0]   s_saturation,
    input  wire logic [h2r_pkg::SV_W-1:0]   s_brightness,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [h2r_pkg::CH_W-1:0]        m_red,
    output logic [h2r_pkg::CH_W-1:0]        m_green,
    output logic [h2r_pkg::CH_W-1:0]        m_blue
);

    // ---------------- stage enables ----------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_en, s2_en, s3_en, s4_en;

    assign s4_en   = !s4_valid_reg || m_ready;
    assign s3_en   = !s3_valid_reg || s4_en;
    assign s2_en   = !s2_valid_reg || s3_en;
    assign s1_en   = !s1_valid_reg || s2_en;
    assign s_ready = s1_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            if (s1_en) s1_valid_reg <= s_valid;
            if (s2_en) s2_valid_reg <= s1_valid_reg;
            if (s3_en) s3_valid_reg <= s2_valid_reg;
            if (s4_en) s4_valid_reg <= s3_valid_reg;
        end
    end

    // ---------------- stage 1: chroma product, hue split ----------------
    h2r_pkg::hue_split_t              split;
    logic [h2r_pkg::VS_W-1:0]         s1_vs_reg, s1_vs_next;
    logic [h2r_pkg::DIST_W-1:0]       s1_gap_reg;
    h2r_pkg::sector_t                 s1_sector_reg;
    logic [h2r_pkg::SV_W-1:0]         s1_v_reg;

    h2r_hue_split u_hue_split (
        .hue   (s_hue),
        .split (split)
    );

    assign s1_vs_next = h2r_pkg::VS_W'(s_brightness) * h2r_pkg::VS_W'(s_saturation);

    always_ff @(posedge aclk) begin
        if (s1_en) begin
            s1_vs_reg     <= s1_vs_next;
            s1_gap_reg    <= split.gap;
            s1_sector_reg <= split.sector;
            s1_v_reg      <= s_brightness;
        end
    end

    // ---------------- stage 2: secondary product, offset ----------------
    // px = vs * d, secondary channel sum = v * 256 * 3840 - px
    logic [29:0]              s2_px_reg, s2_px_next;
    logic [28:0]              s2_vk_reg, s2_vk_next;
    logic [16:0]              s2_z_reg, s2_z_next;
    logic [16:0]              v256;
    h2r_pkg::sector_t         s2_sector_reg;
    logic [h2r_pkg::SV_W-1:0] s2_v_reg;

    assign s2_px_next = 30'(s1_vs_reg) * 30'(s1_gap_reg);
    assign s2_vk_next = (29'(s1_v_reg) << 20) - (29'(s1_v_reg) << 16);
    assign v256       = {s1_v_reg, 8'd0};

    // Zero channel sum over 3840: 256 v - vs, floored at zero
    always_comb begin
        if (18'(v256) > s1_vs_reg) begin
            s2_z_next = 17'(18'(v256) - s1_vs_reg);
        end else begin
            s2_z_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_en) begin
            s2_px_reg     <= s2_px_next;
            s2_vk_reg     <= s2_vk_next;
            s2_z_reg      <= s2_z_next;
            s2_sector_reg <= s1_sector_reg;
            s2_v_reg      <= s1_v_reg;
        end
    end

    // ---------------- stage 3: scale by 255 ----------------
    logic [28:0]                s3_xs;
    logic [36:0]                s3_xp;
    logic [12:0]                s3_xy_full;
    logic [h2r_pkg::DIST_W-1:0] s3_xy_reg, s3_xy_next;
    logic [24:0]                s3_zp;
    logic [16:0]                s3_cp;
    logic [h2r_pkg::CH_W-1:0]   s3_zq_reg, s3_zq_next;
    logic [h2r_pkg::CH_W-1:0]   s3_cq_reg, s3_cq_next;
    h2r_pkg::sector_t           s3_sector_reg;

    always_comb begin
        if (30'(s2_vk_reg) > s2_px_reg) begin
            s3_xs = 29'(30'(s2_vk_reg) - s2_px_reg);
        end else begin
            s3_xs = '0;
        end
        s3_xp      = (37'(s3_xs) << 8) - 37'(s3_xs);
        s3_xy_full = s3_xp[36:24];
        // hold the pre-divide value at 255 * 15 so the quotient saturates
        if (s3_xy_full >= 13'(h2r_pkg::XY_MAX)) begin
            s3_xy_next = h2r_pkg::XY_MAX;
        end else begin
            s3_xy_next = s3_xy_full[11:0];
        end

        s3_zp = (25'(s2_z_reg) << 8) - 25'(s2_z_reg);
        if (s3_zp[24]) begin
            s3_zq_next = h2r_pkg::CH_MAX;
        end else begin
            s3_zq_next = s3_zp[23:16];
        end

        s3_cp = (17'(s2_v_reg) << 8) - 17'(s2_v_reg);
        if (s3_cp[16]) begin
            s3_cq_next = h2r_pkg::CH_MAX;
        end else begin
            s3_cq_next = s3_cp[15:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (s3_en) begin
            s3_xy_reg     <= s3_xy_next;
            s3_zq_reg     <= s3_zq_next;
            s3_cq_reg     <= s3_cq_next;
            s3_sector_reg <= s2_sector_reg;
        end
    end

    // ---------------- stage 4: divide by 15, route to channels ----------------
    logic [27:0]              s4_prod;
    logic [h2r_pkg::CH_W-1:0] s4_xq;
    logic [h2r_pkg::CH_W-1:0] red_reg, red_next;
    logic [h2r_pkg::CH_W-1:0] green_reg, green_next;
    logic [h2r_pkg::CH_W-1:0] blue_reg, blue_next;

    assign s4_prod = 28'(s3_xy_reg) * 28'(h2r_pkg::RECIP15);
    assign s4_xq   = s4_prod[h2r_pkg::RECIP_SH +: h2r_pkg::CH_W];

    always_comb begin
        case (s3_sector_reg)
            h2r_pkg::SECTOR_RED_YELLOW: begin
                red_next = s3_cq_reg; green_next = s4_xq;     blue_next = s3_zq_reg;
            end
            h2r_pkg::SECTOR_YELLOW_GREEN: begin
                red_next = s4_xq;     green_next = s3_cq_reg; blue_next = s3_zq_reg;
            end
            h2r_pkg::SECTOR_GREEN_CYAN: begin
                red_next = s3_zq_reg; green_next = s3_cq_reg; blue_next = s4_xq;
            end
            h2r_pkg::SECTOR_CYAN_BLUE: begin
                red_next = s3_zq_reg; green_next = s4_xq;     blue_next = s3_cq_reg;
            end
            h2r_pkg::SECTOR_BLUE_MAGENTA: begin
                red_next = s4_xq;     green_next = s3_zq_reg; blue_next = s3_cq_reg;
            end
            default: begin
                red_next = s3_cq_reg; green_next = s3_zq_reg; blue_next = s4_xq;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s4_en) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_valid = s4_valid_reg;
    assign m_red   = red_reg;
    assign m_green = green_reg;
    assign m_blue  = blue_reg;

`ifndef NO_ASSERTIONS
    // A stalled first stage keeps its beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s2_en) |=> (s1_valid_reg && $stable(s1_vs_reg)))
        else $error("stage 1 beat lost during stall");

    // Back-pressure at the input only when every stage is full
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg
                      && !m_ready))
        else $error("input stalled with an empty stage");

    // Pre-divide secondary value never exceeds the saturation point
    assert property (@(posedge aclk) disable iff (!aresetn)
        s3_valid_reg |-> (s3_xy_reg <= h2r_pkg::XY_MAX))
        else $error("secondary value above clamp");

    // Hue distance stays within one sector
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> (s1_gap_reg <= h2r_pkg::SECTOR_UNITS[11:0]))
        else $error("hue distance out of range");
`endif

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HSV to RGB converter. A table of colors
// (primaries, sector edges, hue and level limits, out-of-range saturation,
// value and hue) is sent first. About 1500 random colors follow, with random
// gaps on the input side and random stalls on the output side. Every output
// beat is compared in order against its typed table color or else a bit-exact
// integer model of the conversion.
// ----------------------------------------------------------------------------
module tb;

    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     RANDOM_BLOCKS  = 15;
    localparam int     BLOCK_BEATS    = 100;
    localparam int     TABLE_ROWS     = 25;
    localparam int     REPORT_MAX     = 10;
    localparam longint LEVEL_DEN      = longint'(h2r_pkg::SECTOR_UNITS) << 16;

    typedef struct packed {
        logic [h2r_pkg::CH_W-1:0] red;
        logic [h2r_pkg::CH_W-1:0] green;
        logic [h2r_pkg::CH_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [h2r_pkg::HUE_W-1:0] hue;
        logic [h2r_pkg::SV_W-1:0]  sat;
        logic [h2r_pkg::SV_W-1:0]  bri;
        logic                      typed;
        logic [h2r_pkg::CH_W-1:0]  red;
        logic [h2r_pkg::CH_W-1:0]  green;
        logic [h2r_pkg::CH_W-1:0]  blue;
    } probe_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [h2r_pkg::HUE_W-1:0]  s_hue;
    logic [h2r_pkg::SV_W-1:0]   s_saturation;
    logic [h2r_pkg::SV_W-1:0]   s_brightness;
    logic                       m_valid;
    logic                       m_ready;
    logic [h2r_pkg::CH_W-1:0]   m_red;
    logic [h2r_pkg::CH_W-1:0]   m_green;
    logic [h2r_pkg::CH_W-1:0]   m_blue;

    rgb_t        rgb_expected [$];
    bit          no_idle;
    int unsigned color_errors;
    int unsigned sent_count;
    int unsigned checked_count;
    int unsigned wide_count;
    int unsigned drain_pauses;
    int unsigned idle_cycles;

    // hue, saturation, value, typed, red, green, blue
    probe_t color_table [0:TABLE_ROWS-1] = '{
        '{15'd0,     9'd0,   9'd0,   1'b1, 8'd0,   8'd0,   8'd0},
        '{15'd0,     9'd0,   9'd256, 1'b1, 8'd255, 8'd255, 8'd255},
        '{15'd0,     9'd256, 9'd256, 1'b1, 8'd255, 8'd0,   8'd0},
        '{15'd3840,  9'd256, 9'd256, 1'b1, 8'd255, 8'd255, 8'd0},
        '{15'd7680,  9'd256, 9'd256, 1'b1, 8'd0,   8'd255, 8'd0},
        '{15'd11520, 9'd256, 9'd256, 1'b1, 8'd0,   8'd255, 8'd255},
        '{15'd15360, 9'd256, 9'd256, 1'b1, 8'd0,   8'd0,   8'd255},
        '{15'd19200, 9'd256, 9'd256, 1'b1, 8'd255, 8'd0,   8'd255},
        '{15'd23039, 9'd256, 9'd256, 1'b0, 8'd0,   8'd0,   8'd0},
        '{15'd23040, 9'd256, 9'd256, 1'b0, 8'd0,   8'd0,   8'd0},
        '{15'd32767, 9'd256, 9'd256, 1'b0, 8'd0,   8'd0,   8'd0},
        '{15'd0,     9'd511, 9'd256, 1'b1, 8'd255, 8'd0,   8'd0},
        '{15'd3840,  9'd511, 9'd256, 1'b1, 8'd255, 8'd255, 8'd0},
        '{15'd0,     9'd0,   9'd511, 1'b1, 8'd255, 8'd255, 8'd255},
        '{15'd32767, 9'd511, 9'd511, 1'b0, 8'd0,   8'd0,   8'd0},
        '{15'd1920,  9'd128, 9'd200, 1'b0, 8'd0,   8'd0,   8'd0},
        '{15'd5760,  9'd256, 9'd128, 1'b0, 8'd0,   8'd0,   8'd0},
        '{15'd9600,  9'd64,  9'd256, 1'b0, 8'd0,   8'd0,   8'd0},
        '{15'd13440, 9'd200, 9'd100, 1'b0, 8'd0,   8'd0,   8'd0},
        '{15'd17280, 9'd255, 9'd255, 1'b0, 8'd0,   8'd0,   8'd0},
        '{15'd21120, 9'd1,   9'd1,   1'b0, 8'd0,   8'd0,   8'd0},
        '{15'd1,     9'd256, 9'd256, 1'b0, 8'd0,   8'd0,   8'd0},
        '{15'd7679,  9'd256, 9'd256, 1'b0, 8'd0,   8'd0,   8'd0},
        '{15'd16384, 9'd300, 9'd300, 1'b0, 8'd0,   8'd0,   8'd0},
        '{15'd23039, 9'd511, 9'd0,   1'b1, 8'd0,   8'd0,   8'd0}
    };

    hsv_to_rgb_converter dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_hue        (s_hue),
        .s_saturation (s_saturation),
        .s_brightness (s_brightness),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Scale a channel sum in 1/(65536*3840) units to 0..255, floor and clamp.
    function automatic logic [h2r_pkg::CH_W-1:0] to_level(input longint sum);
        longint q;
        if (sum <= 0) begin
            return '0;
        end
        q = (sum * 255) / LEVEL_DEN;
        return (q > 255) ? h2r_pkg::CH_MAX : q[h2r_pkg::CH_W-1:0];
    endfunction

    function automatic rgb_t predict_rgb(input logic [h2r_pkg::HUE_W-1:0] hue,
                                         input logic [h2r_pkg::SV_W-1:0] sat,
                                         input logic [h2r_pkg::SV_W-1:0] bri);
        longint           span;
        longint           chroma_vs;
        longint           phase;
        longint           hue_dist;
        longint           chroma;
        longint           secondary;
        longint           offset;
        longint           sector_idx;
        longint           rch;
        longint           gch;
        longint           bch;
        h2r_pkg::sector_t sector;
        rgb_t             px;
        span      = longint'(h2r_pkg::SECTOR_UNITS);
        chroma_vs = longint'(bri) * longint'(sat);
        phase     = longint'(hue) % (2 * span);
        hue_dist  = phase - span;
        if (hue_dist < 0) begin
            hue_dist = -hue_dist;
        end
        chroma    = chroma_vs * span;
        secondary = chroma_vs * (span - hue_dist);
        offset    = (longint'(bri) * 256 - chroma_vs) * span;
        // hue at or past 360 degrees stays in the last sector
        sector_idx = longint'(hue) / span;
        if (sector_idx > 5) begin
            sector_idx = 5;
        end
        sector = h2r_pkg::sector_t'(sector_idx[2:0]);
        case (sector)
            h2r_pkg::SECTOR_RED_YELLOW: begin
                rch = chroma;    gch = secondary; bch = 0;
            end
            h2r_pkg::SECTOR_YELLOW_GREEN: begin
                rch = secondary; gch = chroma;    bch = 0;
            end
            h2r_pkg::SECTOR_GREEN_CYAN: begin
                rch = 0;         gch = chroma;    bch = secondary;
            end
            h2r_pkg::SECTOR_CYAN_BLUE: begin
                rch = 0;         gch = secondary; bch = chroma;
            end
            h2r_pkg::SECTOR_BLUE_MAGENTA: begin
                rch = secondary; gch = 0;         bch = chroma;
            end
            default: begin
                rch = chroma;    gch = 0;         bch = secondary;
            end
        endcase
        px.red   = to_level(rch + offset);
        px.green = to_level(gch + offset);
        px.blue  = to_level(bch + offset);
        return px;
    endfunction

    function automatic int unsigned pick_wait();
        if (no_idle) begin
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic logic [h2r_pkg::SV_W-1:0] edge_level();
        case ($urandom_range(0, 3))
            0:       return 9'd0;
            1:       return 9'd1;
            2:       return 9'd255;
            default: return 9'd256;
        endcase
    endfunction

    task automatic send_color(input logic [h2r_pkg::HUE_W-1:0] hue,
                              input logic [h2r_pkg::SV_W-1:0] sat,
                              input logic [h2r_pkg::SV_W-1:0] bri, input bit typed,
                              input rgb_t typed_rgb);
        int unsigned gap;
        rgb_t        want_rgb;
        gap = pick_wait();
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_hue        <= hue;
        s_saturation <= sat;
        s_brightness <= bri;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        want_rgb     = typed ? typed_rgb : predict_rgb(hue, sat, bri);
        rgb_expected = {rgb_expected, want_rgb};
        sent_count++;
    endtask

    // Drop valid and hold until the pipeline has delivered every pending beat.
    task automatic pause_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (rgb_expected.size() != 0) @(posedge aclk);
        drain_pauses++;
    endtask

    // Output side: random stall before each beat, then hold ready until taken.
    initial begin : rgb_sink
        int unsigned stall;
        m_ready = 1'b0;
        while (aresetn !== 1'b1) @(negedge aclk);
        forever begin
            stall = pick_wait();
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin : check_beat
        rgb_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            checked_count++;
            if (rgb_expected.size() == 0) begin
                color_errors++;
                if (color_errors <= REPORT_MAX) begin
                    $display("%0t: unexpected beat r=%0d g=%0d b=%0d",
                             $realtime, m_red, m_green, m_blue);
                end
            end else begin
                want = rgb_expected.pop_front();
                if (m_red !== want.red || m_green !== want.green
                        || m_blue !== want.blue) begin
                    color_errors++;
                    if (color_errors <= REPORT_MAX) begin
                        $display("%0t: mismatch expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                 $realtime, want.red, want.green, want.blue,
                                 m_red, m_green, m_blue);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("TB_ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int unsigned               block;
        int unsigned               k;
        int unsigned               kind;
        logic [h2r_pkg::HUE_W-1:0] hue;
        logic [h2r_pkg::SV_W-1:0]  sat;
        logic [h2r_pkg::SV_W-1:0]  bri;
        rgb_t                      typed_rgb;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_hue        = '0;
        s_saturation = '0;
        s_brightness = '0;
        no_idle      = 1'b0;
        idle_cycles  = 0;
        color_errors = 0;
        sent_count   = 0;
        checked_count = 0;
        wide_count   = 0;
        drain_pauses = 0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < TABLE_ROWS; k++) begin
            typed_rgb = '{color_table[k].red, color_table[k].green, color_table[k].blue};
            send_color(color_table[k].hue, color_table[k].sat, color_table[k].bri,
                       color_table[k].typed, typed_rgb);
        end
        pause_until_drained();

        for (block = 0; block < RANDOM_BLOCKS; block++) begin
            // some blocks run back to back with no gaps or stalls at all
            no_idle = ($urandom_range(0, 3) == 0);
            for (k = 0; k < BLOCK_BEATS; k++) begin
                kind = $urandom_range(0, 9);
                if (kind < 7) begin
                    hue = h2r_pkg::HUE_W'($urandom_range(0, 23039));
                    sat = h2r_pkg::SV_W'($urandom_range(0, 256));
                    bri = h2r_pkg::SV_W'($urandom_range(0, 256));
                end else if (kind < 8) begin
                    // near a sector boundary, levels at their limits
                    hue = h2r_pkg::HUE_W'($urandom_range(0, 6) * 3840);
                    case ($urandom_range(0, 2))
                        0:       hue = (hue == '0) ? hue : hue - 15'd1;
                        1:       hue = hue + 15'd1;
                        default: hue = hue;
                    endcase
                    sat = edge_level();
                    bri = edge_level();
                end else begin
                    hue = h2r_pkg::HUE_W'($urandom_range(0, 32767));
                    sat = h2r_pkg::SV_W'($urandom_range(0, 511));
                    bri = h2r_pkg::SV_W'($urandom_range(0, 511));
                    wide_count++;
                end
                send_color(hue, sat, bri, 1'b0, '0);
            end
            if ($urandom_range(0, 4) == 0) begin
                pause_until_drained();
            end
        end
        no_idle = 1'b0;

        pause_until_drained();
        repeat (10) @(posedge aclk);

        $display("sent %0d colors (%0d from the table, %0d over the full field range),",
                 sent_count, TABLE_ROWS, wide_count);
        $display("checked %0d RGB beats, drained the pipeline %0d times, %0d mismatches",
                 checked_count, drain_pauses, color_errors);
        if (color_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ hsv_to_rgb_converter.f @@
rtl/core/h2r_pkg.sv
rtl/core/h2r_hue_split.sv
rtl/core/hsv_to_rgb_converter.sv
sim/tb.sv
